FILE: hw/rtl/cosine_topk_neighbor_search_top_defines.svh
// ---------------------------------------------------------------------------
// cosine top-k neighbor search assertion macros
// concurrent checks on clk_i and rst_ni, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef COSINE_TOPK_NEIGHBOR_SEARCH_TOP_DEFINES_SVH
`define COSINE_TOPK_NEIGHBOR_SEARCH_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTNSK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ctnsk check failed");
`define CTNSK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctnsk check failed");
`else
`define CTNSK_ASSERT(lbl, prop)
`define CTNSK_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/ctnsk_pkg.sv
// ---------------------------------------------------------------------------
// ctnsk_pkg
// shared widths, codes and request types of the cosine top-k search
// ---------------------------------------------------------------------------
package ctnsk_pkg;

  localparam int ROW_W     = 10;
  localparam int COL_W     = 6;
  localparam int VAL_W     = 16;
  localparam int ROWS_MAX  = 1024;
  localparam int DIM_MAX   = 64;
  localparam int K_MAX     = 8;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int TBL_DEPTH = ROWS_MAX * DIM_MAX;
  localparam int SQ_W      = 37;
  localparam int DOT_W     = 38;
  localparam int RAD_W     = SQ_W + 8;
  localparam int NORM_W    = 23;
  localparam int MUL_W     = 24;
  localparam int MULP_W    = 2 * MUL_W;
  localparam int DEN_W     = 46;
  localparam int QUO_W     = 15;
  localparam int REM_W     = DEN_W + QUO_W;
  localparam int SCORE_W   = 16;
  localparam int SCORE_ONE = 16384;
  localparam int CNT_W     = 4;
  localparam int RANK_W    = 3;
  localparam int VOC_W     = 11;
  localparam int DIM_W     = 7;
  localparam int K_W       = 4;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] STAT_NEIGHBOR = 2'd0;
  localparam logic [1:0] STAT_NOVOCAB  = 2'd1;
  localparam logic [1:0] STAT_NONE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_VOCAB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOPK  = 2'd2;

  typedef struct packed {
    logic               func;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [RANK_W-1:0]  rank;
    logic [ROW_W-1:0]   neighbor_id;
    logic signed [SCORE_W-1:0] score;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_Q, ST_RD_C, ST_MUL_SQ, ST_MUL_DOT, ST_ACC, ST_SQRT_GO,
    ST_SQRT_WAIT, ST_SEL, ST_DEN, ST_DIV_GO, ST_DIV_WAIT, ST_INSERT, ST_FIN,
    ST_EMIT
  } state_e;

endpackage

FILE: hw/rtl/ctnsk_ram.sv
// ---------------------------------------------------------------------------
// ctnsk_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module ctnsk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/ctnsk_sqrt.sv
// ---------------------------------------------------------------------------
// ctnsk_sqrt
// iterative integer square root, one result bit per cycle
// ---------------------------------------------------------------------------
module ctnsk_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ctnsk_pkg::RAD_W-1:0]  rad_i,
  output logic                         done_o,
  output logic [ctnsk_pkg::NORM_W-1:0] root_o
);
  import ctnsk_pkg::*;

  localparam int TOP = (RAD_W - 1) - ((RAD_W - 1) % 2);

  logic             busy_q, done_q;
  logic [RAD_W-1:0] x_q, x_d, r_q, r_d, bit_q, trial;

  always_comb begin
    trial = r_q + bit_q;
    if (x_q >= trial) begin
      x_d = x_q - trial;
      r_d = (r_q >> 1) + bit_q;
    end else begin
      x_d = x_q;
      r_d = r_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= rad_i;
      r_q   <= '0;
      bit_q <= RAD_W'(1) << TOP;
    end else if (busy_q) begin
      x_q   <= x_d;
      r_q   <= r_d;
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[NORM_W-1:0];

endmodule

FILE: hw/rtl/ctnsk_div.sv
// ---------------------------------------------------------------------------
// ctnsk_div
// restoring divider for the q1.14 score, one quotient bit per cycle
// ---------------------------------------------------------------------------
module ctnsk_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [ctnsk_pkg::DOT_W-1:0]  dot_i,
  input  logic [ctnsk_pkg::DEN_W-1:0]         den_i,
  output logic                                done_o,
  output logic signed [ctnsk_pkg::SCORE_W-1:0] score_o
);
  import ctnsk_pkg::*;

  logic             busy_q, done_q, neg_q, sat_q;
  logic [3:0]       step_q;
  logic [REM_W-1:0] rem_q, dsh_q, num;
  logic [QUO_W-1:0] quo_q, quo_c;
  logic [DOT_W-1:0] mag;
  logic             ge;

  assign mag = dot_i[DOT_W-1] ? DOT_W'(-dot_i) : DOT_W'(dot_i);
  assign num = {2'b00, mag[DOT_W-2:0], 22'd0};
  assign ge  = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == 4'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 4'(QUO_W - 1);
      end else if (busy_q) begin
        if (step_q == 4'd0) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dot_i[DOT_W-1];
      sat_q <= num >= {den_i, 15'd0};
      rem_q <= num;
      dsh_q <= {1'b0, den_i, 14'd0};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  // saturate to plus or minus one
  assign quo_c   = (sat_q || quo_q > QUO_W'(SCORE_ONE)) ? QUO_W'(SCORE_ONE) : quo_q;
  assign score_o = neg_q ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});
  assign done_o  = done_q;

endmodule

FILE: hw/rtl/ctnsk_topk.sv
// ---------------------------------------------------------------------------
// ctnsk_topk
// sorted best list, earlier entries win ties
// ---------------------------------------------------------------------------
module ctnsk_topk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clr_i,
  input  logic                                 ins_i,
  input  logic [ctnsk_pkg::K_W-1:0]            k_i,
  input  logic signed [ctnsk_pkg::SCORE_W-1:0] score_i,
  input  logic [ctnsk_pkg::ROW_W-1:0]          id_i,
  input  logic [ctnsk_pkg::RANK_W-1:0]         rd_idx_i,
  output logic [ctnsk_pkg::CNT_W-1:0]          cnt_o,
  output logic signed [ctnsk_pkg::SCORE_W-1:0] rd_score_o,
  output logic [ctnsk_pkg::ROW_W-1:0]          rd_id_o
);
  import ctnsk_pkg::*;

  logic signed [SCORE_W-1:0] score_q [K_MAX];
  logic [ROW_W-1:0]          id_q [K_MAX];
  logic [CNT_W-1:0]          cnt_q;
  logic [K_MAX-1:0]          hit;
  logic [RANK_W-1:0]         slot;
  logic                      found;

  always_comb begin
    slot  = '0;
    found = 1'b0;
    for (int j = 0; j < K_MAX; j++) begin
      hit[j] = (CNT_W'(j) < k_i) && ((CNT_W'(j) >= cnt_q) || (score_i > score_q[j]));
      if (hit[j] && !found) begin
        slot  = RANK_W'(j);
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (clr_i) begin
      cnt_q <= '0;
    end else if (ins_i && found && (cnt_q < k_i)) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i && found) begin
      for (int j = 0; j < K_MAX; j++) begin
        if (RANK_W'(j) == slot) begin
          score_q[j] <= score_i;
          id_q[j]    <= id_i;
        end else if (RANK_W'(j) > slot) begin
          score_q[j] <= score_q[(j > 0) ? j - 1 : 0];
          id_q[j]    <= id_q[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  assign cnt_o      = cnt_q;
  assign rd_score_o = score_q[rd_idx_i];
  assign rd_id_o    = id_q[rd_idx_i];

endmodule

FILE: hw/rtl/cosine_topk_neighbor_search_top.sv
// ---------------------------------------------------------------------------
// cosine_topk_neighbor_search_top
// cosine similarity top-k nearest neighbor search over an embedding table
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o) takes requests of two kinds:
//   a write stores one q2.13 element at row, column and gives no
//   result; a query names a row and walks all other rows in use
//   output channel (out_valid_o / out_stall_i) gives the sorted neighbors,
//   rank 0 first, last set on the final one; a query row outside the
//   vocabulary or an empty list gives one status result instead
//   a query makes one norm pass for the query row, then a norm pass and a
//   score for each other row in use; the table ram port and the shared
//   24x24 multiplier serve one element product at a time, then the norm
//   root and the score division run in their own iterative units
//   while a query runs in_stall_o stays high; a finished result sits in an
//   output register, so the next request is taken while it waits
//   reset clears the control state and loads vocab_size 800, embed_dim 32,
//   top_k 5; table contents are undefined until written
//   a stalled receiver holds the output register and pauses the emit step
//   config writes are taken at any time but are meant for idle periods
// ---------------------------------------------------------------------------
`include "cosine_topk_neighbor_search_top_defines.svh"

module cosine_topk_neighbor_search_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ctnsk_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ctnsk_pkg::out_item_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ctnsk_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ctnsk_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import ctnsk_pkg::*;

  state_e state_q, state_d;

  // config registers and their clamped values
  logic [VOC_W-1:0] vocab_q, vs_c;
  logic [DIM_W-1:0] dim_q, dim_c;
  logic [K_W-1:0]   topk_q, k_c;

  // scan state
  logic [ROW_W-1:0]  q_row_q;
  logic [VOC_W-1:0]  cand_q;
  logic [COL_W-1:0]  col_q;
  logic              qphase_q;
  logic [SQ_W-1:0]   sq_q;
  logic signed [DOT_W-1:0]  dot_q;
  logic signed [VAL_W-1:0]  qv_q, cv_q;
  logic signed [MULP_W-1:0] prod_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [NORM_W-1:0] qnorm_q, nc_q;
  logic [RANK_W-1:0] emit_idx_q;
  logic [1:0]        em_status_q;

  // output register
  logic      out_valid_q, out_free, out_load;
  out_item_t out_q, out_d;

  // ram, units
  logic              in_acc, ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;
  logic              sqrt_go, sqrt_done, div_go, div_done, ins_go, clr_go;
  logic [NORM_W-1:0] root;
  logic [SQ_W-1:0]   sq_fl;
  logic signed [SCORE_W-1:0] div_score, rd_score;
  logic [ROW_W-1:0]  rd_id;
  logic [CNT_W-1:0]  topk_cnt;
  logic              last_col, row_bad, emit_last;

  assign vs_c  = (vocab_q > VOC_W'(ROWS_MAX)) ? VOC_W'(ROWS_MAX) : vocab_q;
  assign dim_c = (dim_q > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : dim_q;
  assign k_c   = (topk_q > K_W'(K_MAX)) ? K_W'(K_MAX) : topk_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign ram_we   = in_acc && (in_data_i.func == FUNC_WRITE);
  assign row_bad  = {1'b0, in_data_i.row} >= vs_c;
  assign last_col = {1'b0, col_q} == (dim_c - DIM_W'(1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_last = (em_status_q != STAT_NEIGHBOR)
                   || ((CNT_W'(emit_idx_q) + CNT_W'(1)) == topk_cnt);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vocab_q <= VOC_W'(800);
      dim_q   <= DIM_W'(32);
      topk_q  <= K_W'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VOCAB: vocab_q <= cfg_wdata_i[VOC_W-1:0];
        CFG_DIM:   dim_q   <= cfg_wdata_i[DIM_W-1:0];
        CFG_TOPK:  topk_q  <= cfg_wdata_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.func == FUNC_QUERY) begin
          if (row_bad) begin
            state_d = ST_EMIT;
          end else if (dim_c == '0) begin
            state_d = ST_SQRT_GO;
          end else begin
            state_d = ST_RD_Q;
          end
        end
      end
      ST_RD_Q:    state_d = ST_RD_C;
      ST_RD_C:    state_d = ST_MUL_SQ;
      ST_MUL_SQ:  state_d = ST_MUL_DOT;
      ST_MUL_DOT: state_d = ST_ACC;
      ST_ACC:     state_d = last_col ? ST_SQRT_GO : ST_RD_Q;
      ST_SQRT_GO: state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_d = qphase_q ? ST_SEL : ST_DEN;
        end
      end
      ST_SEL: begin
        if (cand_q >= vs_c) begin
          state_d = ST_FIN;
        end else if (cand_q != {1'b0, q_row_q}) begin
          state_d = (dim_c == '0) ? ST_SQRT_GO : ST_RD_Q;
        end
      end
      ST_DEN:     state_d = ST_DIV_GO;
      ST_DIV_GO:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT:  state_d = ST_SEL;
      ST_FIN:     state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    ram_raddr  = {cand_q[ROW_W-1:0], col_q};
    mul_a      = $signed({1'b0, qnorm_q});
    mul_b      = $signed({1'b0, nc_q});
    sqrt_go    = 1'b0;
    div_go     = 1'b0;
    ins_go     = 1'b0;
    clr_go     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        clr_go     = in_valid_i && (in_data_i.func == FUNC_QUERY);
      end
      ST_RD_Q:  ram_raddr = {q_row_q, col_q};
      ST_MUL_SQ: begin
        mul_a = MUL_W'($signed(ram_rdata));
        mul_b = MUL_W'($signed(ram_rdata));
      end
      ST_MUL_DOT: begin
        mul_a = MUL_W'(qv_q);
        mul_b = MUL_W'(cv_q);
      end
      ST_SQRT_GO: sqrt_go  = 1'b1;
      ST_DIV_GO:  div_go   = 1'b1;
      ST_INSERT:  ins_go   = 1'b1;
      ST_EMIT:    out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // squared norm floored at one lsb, scaled by 2^8
  assign sq_fl = (sq_q == '0) ? SQ_W'(1) : sq_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (out_load) begin
      out_q <= out_d;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.func == FUNC_QUERY) begin
          q_row_q     <= in_data_i.row;
          cand_q      <= {1'b0, in_data_i.row};
          qphase_q    <= 1'b1;
          col_q       <= '0;
          sq_q        <= '0;
          dot_q       <= '0;
          emit_idx_q  <= '0;
          em_status_q <= row_bad ? STAT_NOVOCAB : STAT_NEIGHBOR;
        end
      end
      ST_RD_C:    qv_q <= $signed(ram_rdata);
      ST_MUL_SQ:  cv_q <= $signed(ram_rdata);
      ST_MUL_DOT: sq_q <= sq_q + SQ_W'(prod_q[30:0]);
      ST_ACC: begin
        // signed element product, sign extended into the accumulator
        dot_q <= dot_q + DOT_W'($signed(prod_q[31:0]));
        col_q <= col_q + COL_W'(1);
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          if (qphase_q) begin
            qnorm_q  <= root;
            qphase_q <= 1'b0;
            cand_q   <= '0;
          end else begin
            nc_q <= root;
          end
        end
      end
      ST_SEL: begin
        if (cand_q < vs_c) begin
          if (cand_q == {1'b0, q_row_q}) begin
            cand_q <= cand_q + VOC_W'(1);
          end else begin
            col_q <= '0;
            sq_q  <= '0;
            dot_q <= '0;
          end
        end
      end
      ST_INSERT: cand_q <= cand_q + VOC_W'(1);
      ST_FIN: em_status_q <= (topk_cnt == '0) ? STAT_NONE : STAT_NEIGHBOR;
      ST_EMIT: begin
        if (out_free) begin
          emit_idx_q <= emit_idx_q + RANK_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d.status      = em_status_q;
    out_d.rank        = (em_status_q == STAT_NEIGHBOR) ? emit_idx_q : '0;
    out_d.neighbor_id = (em_status_q == STAT_NEIGHBOR) ? rd_id : '0;
    out_d.score       = (em_status_q == STAT_NEIGHBOR) ? rd_score : '0;
    out_d.last        = emit_last;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ctnsk_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({in_data_i.row, in_data_i.column}),
    .wdata_i (in_data_i.value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ctnsk_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_go),
    .rad_i   ({sq_fl, 8'd0}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  ctnsk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .dot_i   (dot_q),
    .den_i   (prod_q[DEN_W-1:0]),
    .done_o  (div_done),
    .score_o (div_score)
  );

  ctnsk_topk u_topk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (clr_go),
    .ins_i      (ins_go),
    .k_i        (k_c),
    .score_i    (div_score),
    .id_i       (cand_q[ROW_W-1:0]),
    .rd_idx_i   (emit_idx_q),
    .cnt_o      (topk_cnt),
    .rd_score_o (rd_score),
    .rd_id_o    (rd_id)
  );

  // unit handshakes only complete in their wait states
  `CTNSK_ASSERT_IMPL(a_sqrt_done_wait, sqrt_done, state_q == ST_SQRT_WAIT)
  `CTNSK_ASSERT_IMPL(a_div_done_wait, div_done, state_q == ST_DIV_WAIT)
  // the list never holds more than its storage
  `CTNSK_ASSERT(a_cnt_bound, topk_cnt <= CNT_W'(K_MAX))
  // neighbor results only come from a filled list
  `CTNSK_ASSERT_IMPL(a_emit_filled, state_q == ST_EMIT && em_status_q == STAT_NEIGHBOR, topk_cnt != '0)

endmodule

FILE: sim/tb_cosine_topk_neighbor_search_top.sv
// ----------------------------------------------------------------------------
// cosine top-k neighbor search testbench
// directed steps from a table, then random write/query traffic over several
// register settings; every result is checked against a built-in scorer
// or against a status typed in by hand
module tb_cosine_topk_neighbor_search_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ctnsk_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 2000;

  typedef enum int {STEP_ITEM, STEP_CFG, STEP_FILL} step_kind_e;

  // one row of the directed table; has_exp marks a result typed in by hand
  typedef struct {
    step_kind_e kind;
    int         a;
    int         b;
    int         c;
    int         d;
    bit         has_exp;
    logic [1:0] exp_status;
  } step_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  cosine_topk_neighbor_search_top dut (.*);

  // scorer state: its own copy of the table and the registers
  logic signed [VAL_W-1:0] emb_mem [0:TBL_DEPTH-1];
  bit emb_written [0:TBL_DEPTH-1];
  int unsigned vocab_reg = 800;
  int unsigned dim_reg = 32;
  int unsigned topk_reg = 5;

  out_item_t neighbor_q[$];
  step_t directed_steps[$];
  int errors = 0;
  longint unsigned cycle_cnt = 0;

  // idle percentages for both sides, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req;
  bit hold_done = 0;
  int hold_cnt = 0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // watchdog against a hung block
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_field(string name, longint expv, longint actv);
    $display("%0t mismatch %s expected %0d actual %0d", $time, name, expv, actv);
    errors++;
  endtask

  // result checker: oldest expectation against each accepted result
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (neighbor_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        want = neighbor_q.pop_front();
        if (out_data_o.status !== want.status)
          report_field("status", want.status, out_data_o.status);
        if (out_data_o.rank !== want.rank)
          report_field("rank", want.rank, out_data_o.rank);
        if (out_data_o.neighbor_id !== want.neighbor_id)
          report_field("neighbor_id", want.neighbor_id, out_data_o.neighbor_id);
        if (out_data_o.score !== want.score)
          report_field("score", want.score, out_data_o.score);
        if (out_data_o.last !== want.last)
          report_field("last", want.last, out_data_o.last);
      end
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // norm in units of 2^-17, squared sum floored at one lsb
  function automatic longint unsigned emb_norm(int r, int dim);
    longint unsigned s = 0;
    longint v;
    for (int i = 0; i < dim; i++) begin
      v = emb_mem[r * DIM_MAX + i];
      s += v * v;
    end
    if (s < 1) s = 1;
    return int_sqrt(s << 8);
  endfunction

  function automatic longint emb_dot(int a, int b, int dim);
    longint s = 0;
    for (int i = 0; i < dim; i++)
      s += longint'(emb_mem[a * DIM_MAX + i]) * longint'(emb_mem[b * DIM_MAX + i]);
    return s;
  endfunction

  function automatic logic signed [SCORE_W-1:0] cosine_score(longint d,
      longint unsigned nq, longint unsigned nc);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : d;
    q = (mag << 22) / (nq * nc);
    if (q > SCORE_ONE) q = SCORE_ONE;
    return (d < 0) ? -SCORE_W'(q) : SCORE_W'(q);
  endfunction

  // update the table copy or push the sorted neighbor list or status of a query
  task automatic predict_neighbors(in_item_t it);
    int vs, dim, k, cnt, slot, qrow;
    longint unsigned qn;
    logic signed [SCORE_W-1:0] sc;
    logic signed [SCORE_W-1:0] top_score [K_MAX];
    int top_id [K_MAX];
    if (it.func == FUNC_WRITE) begin
      emb_mem[{it.row, it.column}] = it.value;
      return;
    end
    vs = (vocab_reg > ROWS_MAX) ? ROWS_MAX : vocab_reg;
    dim = (dim_reg > DIM_MAX) ? DIM_MAX : dim_reg;
    k = (topk_reg > K_MAX) ? K_MAX : topk_reg;
    qrow = it.row;
    if (qrow >= vs) begin
      neighbor_q.push_back('{STAT_NOVOCAB, 0, 0, 0, 1'b1});
      return;
    end
    cnt = 0;
    qn = emb_norm(qrow, dim);
    for (int i = 0; i < vs; i++) begin
      if (i == qrow) continue;
      sc = cosine_score(emb_dot(qrow, i, dim), qn, emb_norm(i, dim));
      slot = k;
      for (int j = 0; j < k; j++) begin
        if (j >= cnt || sc > top_score[j]) begin
          slot = j;
          break;
        end
      end
      if (slot >= k) continue;
      if (cnt < k) cnt++;
      for (int j = cnt - 1; j > slot; j--) begin
        top_score[j] = top_score[j-1];
        top_id[j] = top_id[j-1];
      end
      top_score[slot] = sc;
      top_id[slot] = i;
    end
    if (cnt == 0) begin
      neighbor_q.push_back('{STAT_NONE, 0, 0, 0, 1'b1});
      return;
    end
    for (int j = 0; j < cnt; j++)
      neighbor_q.push_back('{STAT_NEIGHBOR, RANK_W'(j), ROW_W'(top_id[j]), top_score[j],
                             (j + 1 == cnt)});
  endtask

  // offer one request; keeps valid high into the next one when no gap is drawn
  task automatic send_request(in_item_t it, bit typed, logic [1:0] typed_status);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    if (typed) neighbor_q.push_back('{typed_status, 0, 0, 0, 1'b1});
    else predict_neighbors(it);
  endtask

  task automatic send_write(int r, int c, int v);
    in_item_t it;
    it.func = FUNC_WRITE;
    it.row = ROW_W'(r);
    it.column = COL_W'(c);
    it.value = VAL_W'(v);
    emb_written[{it.row, it.column}] = 1'b1;
    send_request(it, 1'b0, STAT_NEIGHBOR);
  endtask

  task automatic send_query(int r);
    in_item_t it;
    it = '0;
    it.func = FUNC_QUERY;
    it.row = ROW_W'(r);
    it.column = COL_W'($urandom);
    it.value = VAL_W'($urandom);
    send_request(it, 1'b0, STAT_NEIGHBOR);
  endtask

  // tie-prone, extreme or plain random element values
  function automatic int pick_value();
    int sel = $urandom_range(99);
    if (sel < 25) return ($urandom_range(3) - 1) * 8192;
    if (sel < 35) return $urandom_range(1) ? 32767 : -32768;
    return $urandom_range(65535) - 32768;
  endfunction

  // every element a query can read gets written first
  task automatic fill_region();
    int vs, dim;
    vs = (vocab_reg > ROWS_MAX) ? ROWS_MAX : vocab_reg;
    dim = (dim_reg > DIM_MAX) ? DIM_MAX : dim_reg;
    for (int r = 0; r < vs; r++)
      for (int c = 0; c < dim; c++)
        if (!emb_written[r * DIM_MAX + c]) send_write(r, c, pick_value());
  endtask

  // drain everything, let the block settle, then write a register
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (neighbor_q.size() != 0 || in_stall_o) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_VOCAB: vocab_reg = val & 11'h7FF;
      CFG_DIM:   dim_reg = val & 7'h7F;
      CFG_TOPK:  topk_reg = val & 4'hF;
      default: ;
    endcase
  endtask

  task automatic random_phase(int vocab, int dim, int k, int n_items, bit pressure);
    int vs, dm;
    write_register(CFG_VOCAB, vocab);
    write_register(CFG_DIM, dim);
    write_register(CFG_TOPK, k);
    fill_region();
    vs = (vocab > ROWS_MAX) ? ROWS_MAX : vocab;
    dm = (dim > DIM_MAX) ? DIM_MAX : dim;
    // a query right at the start of the hold-off keeps results backed up
    if (pressure) begin
      hold_req <= 1'b1;
      send_query(0);
    end
    for (int n = 0; n < n_items; n++) begin
      // queries mostly inside the vocabulary; some noise writes anywhere
      if ($urandom_range(99) < 12) begin
        if ($urandom_range(99) < 85) send_query($urandom_range(vs - 1));
        else send_query($urandom_range(1023));
      end else if ($urandom_range(99) < 80) begin
        send_write($urandom_range(vs - 1), $urandom_range(dm - 1), pick_value());
      end else begin
        send_write($urandom_range(1023), $urandom_range(63), pick_value());
      end
    end
  endtask

  function automatic step_t item_step(int func, int r, int c, int v);
    return '{STEP_ITEM, func, r, c, v, 1'b0, STAT_NEIGHBOR};
  endfunction

  function automatic step_t status_step(int r, logic [1:0] st);
    return '{STEP_ITEM, FUNC_QUERY, r, 0, 0, 1'b1, st};
  endfunction

  function automatic step_t cfg_step(int idx, int v);
    return '{STEP_CFG, idx, 0, 0, v, 1'b0, STAT_NEIGHBOR};
  endfunction

  initial begin
    step_t s;
    in_item_t it;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    hold_req = 1'b0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      emb_mem[i] = '0;
      emb_written[i] = 1'b0;
    end

    // after reset: vocabulary 800, so high rows are out of range
    directed_steps.push_back(status_step(1000, STAT_NOVOCAB));
    directed_steps.push_back(status_step(1023, STAT_NOVOCAB));
    // single-row vocabulary: nothing to compare against
    directed_steps.push_back(cfg_step(CFG_VOCAB, 1));
    directed_steps.push_back(cfg_step(CFG_DIM, 8));
    directed_steps.push_back('{STEP_FILL, 0, 0, 0, 0, 1'b0, STAT_NEIGHBOR});
    directed_steps.push_back(status_step(0, STAT_NONE));
    directed_steps.push_back(status_step(5, STAT_NOVOCAB));
    // value extremes, ties between rows, last row as query
    directed_steps.push_back(cfg_step(CFG_VOCAB, 12));
    directed_steps.push_back(cfg_step(CFG_DIM, 4));
    directed_steps.push_back(cfg_step(CFG_TOPK, 3));
    directed_steps.push_back('{STEP_FILL, 0, 0, 0, 0, 1'b0, STAT_NEIGHBOR});
    directed_steps.push_back(item_step(FUNC_WRITE, 0, 0, 32767));
    directed_steps.push_back(item_step(FUNC_WRITE, 1, 0, -32768));
    directed_steps.push_back(item_step(FUNC_WRITE, 2, 0, 32767));
    directed_steps.push_back(item_step(FUNC_WRITE, 1, 63, 0));
    directed_steps.push_back(item_step(FUNC_QUERY, 0, 0, 0));
    directed_steps.push_back(item_step(FUNC_QUERY, 1, 0, 0));
    directed_steps.push_back(item_step(FUNC_QUERY, 11, 0, 0));
    // zero dimension: every score zero, earliest rows win
    directed_steps.push_back(cfg_step(CFG_DIM, 0));
    directed_steps.push_back(cfg_step(CFG_TOPK, 8));
    directed_steps.push_back(item_step(FUNC_QUERY, 3, 0, 0));
    // empty list
    directed_steps.push_back(cfg_step(CFG_TOPK, 0));
    directed_steps.push_back(status_step(2, STAT_NONE));
    // oversized dimension and list length clamp
    directed_steps.push_back(cfg_step(CFG_VOCAB, 2));
    directed_steps.push_back(cfg_step(CFG_DIM, 127));
    directed_steps.push_back(cfg_step(CFG_TOPK, 15));
    directed_steps.push_back('{STEP_FILL, 0, 0, 0, 0, 1'b0, STAT_NEIGHBOR});
    directed_steps.push_back(item_step(FUNC_QUERY, 0, 0, 0));
    directed_steps.push_back(item_step(FUNC_QUERY, 1, 0, 0));
    // oversized vocabulary clamps to the full table, zero dimension reads nothing
    directed_steps.push_back(cfg_step(CFG_VOCAB, 2047));
    directed_steps.push_back(cfg_step(CFG_DIM, 0));
    directed_steps.push_back(cfg_step(CFG_TOPK, 1));
    directed_steps.push_back(item_step(FUNC_WRITE, 1023, 0, -1));
    directed_steps.push_back(item_step(FUNC_QUERY, 1023, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 25;
    recv_idle_pct = 83;
    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      case (s.kind)
        STEP_CFG:  write_register(CFG_IDX_W'(s.a), s.d);
        STEP_FILL: fill_region();
        default: begin
          if (s.a == FUNC_WRITE) begin
            send_write(s.b, s.c, s.d);
          end else begin
            it = '0;
            it.func = FUNC_QUERY;
            it.row = ROW_W'(s.b);
            send_request(it, s.has_exp, s.exp_status);
          end
        end
      endcase
    end

    random_phase(16, 6, 8, 30, 1'b0);
    send_idle_pct = 83;
    recv_idle_pct = 25;
    random_phase(9, 2, 3, 30, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(24, 4, 15, 40, 1'b1);

    in_valid_i <= 1'b0;
    while (neighbor_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
